// File: src/assert_macros.svh
// assertion helpers shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is high
`define CHK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define CHK_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/ddts_pkg.sv
`default_nettype none

package ddts_pkg;

   localparam int VAR_W          = 10;
   localparam int DEF_STACK_DEPTH = 32;

   // item kinds on the request side
   typedef enum logic [1:0] {
      KIND_DECIDE    = 2'd0,
      KIND_BACKTRACK = 2'd1,
      KIND_CLEAR     = 2'd2,
      KIND_NONE      = 2'd3
   } kind_type;

   // event codes on the response side
   typedef enum logic [2:0] {
      EV_ACCEPT   = 3'd0,
      EV_UNASSIGN = 3'd1,
      EV_SUGGEST  = 3'd2,
      EV_UNSAT    = 3'd3,
      EV_OVERFLOW = 3'd4
   } event_type;

   // one trail node
   typedef struct packed {
      logic [VAR_W-1:0] node_var;
      logic             tried_pos;
      logic             tried_neg;
      logic             last_neg;
   } node_type;

   // shift control for one cell
   typedef struct packed {
      logic load_above;
      logic load_below;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: src/dpll_decision_trail_stack.sv
`default_nettype none

// Decision trail of a DPLL solver kept as a row of STACK_DEPTH stack cells, top of stack in
// cell 0; a push shifts every node one cell down, a pop shifts them one cell up. A decide or
// clear transfer gives one response. A backtrack transfer gives one response per popped node,
// then an unassign and a suggestion, or unsat, and holds the request side until the last of
// them is issued: the single response register takes one result per cycle while the response
// side does not stall, and each step looks only at the top cell. A stall holds the walk.
// There is no clearing pass after reset; only nodes below the fill count are ever read.
// req_tready follows rsp_tready combinationally while a response waits.
module dpll_decision_trail_stack #(
   parameter int STACK_DEPTH = ddts_pkg::DEF_STACK_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // lit_var [9:0], lit_neg [10], zeros above
   input  wire logic [1:0]  req_tuser,   // kind [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_var [9:0], out_neg [10], zeros above
   output logic [2:0]       rsp_tuser,   // event_res [2:0]
   output logic             rsp_tlast
);
   import ddts_pkg::*;

   localparam int DW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_SUGG = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic             rsp_valid_ff, rsp_valid_in;
   event_type        rsp_event_ff, rsp_event_in;
   logic [VAR_W-1:0] rsp_var_ff, rsp_var_in;
   logic             rsp_neg_ff, rsp_neg_in;
   logic             rsp_last_ff, rsp_last_in;

   node_type         cell_q [STACK_DEPTH];
   cell_ctl_type     cell_ctl [STACK_DEPTH];
   node_type         top_node;
   node_type         new_node;
   logic             do_push, do_pop, do_update;

   logic             out_free;
   logic             req_xfer;
   kind_type         req_kind;
   logic [VAR_W-1:0] req_var;
   logic             req_neg;
   logic             top_match;
   logic             top_done;

   assign req_kind = kind_type'(req_tuser);
   assign req_var  = req_tdata[VAR_W-1:0];
   assign req_neg  = req_tdata[VAR_W];
   assign top_node = cell_q[0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer   = req_tvalid && req_tready;

   // decide updates the top node when it names its variable and the opposite polarity was tried
   assign top_match = (depth_ff != '0) && (top_node.node_var == req_var) &&
                      ((top_node.tried_pos && req_neg) || (top_node.tried_neg && !req_neg));
   assign top_done  = top_node.tried_pos && top_node.tried_neg;

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_event_in = rsp_event_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_last_in  = rsp_last_ff;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      do_update    = 1'b0;
      new_node     = '{node_var: req_var, tried_pos: !req_neg, tried_neg: req_neg,
                       last_neg: req_neg};
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_kind)
                  KIND_DECIDE: begin
                     rsp_valid_in = 1'b1;
                     rsp_var_in   = req_var;
                     rsp_neg_in   = req_neg;
                     rsp_last_in  = 1'b1;
                     rsp_event_in = EV_ACCEPT;
                     if (top_match) begin
                        do_update = 1'b1;
                        new_node  = '{node_var: top_node.node_var,
                                      tried_pos: top_node.tried_pos | !req_neg,
                                      tried_neg: top_node.tried_neg | req_neg,
                                      last_neg: req_neg};
                     end else if (depth_ff == DW'(STACK_DEPTH)) begin
                        rsp_event_in = EV_OVERFLOW;
                     end else begin
                        do_push  = 1'b1;
                        depth_in = depth_ff + 1'b1;
                     end
                  end
                  KIND_BACKTRACK: begin
                     state_in = ST_WALK;
                  end
                  KIND_CLEAR: begin
                     depth_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_event_in = EV_ACCEPT;
                     rsp_var_in   = '0;
                     rsp_neg_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                     // unused kind: no response
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_var_in   = top_node.node_var;
               rsp_event_in = EV_UNASSIGN;
               rsp_last_in  = 1'b0;
               if (depth_ff == '0) begin
                  rsp_event_in = EV_UNSAT;
                  rsp_var_in   = '0;
                  rsp_neg_in   = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else if (top_done) begin
                  rsp_neg_in = top_node.last_neg;
                  do_pop     = 1'b1;
                  depth_in   = depth_ff - 1'b1;
               end else begin
                  rsp_neg_in = top_node.tried_neg;
                  state_in   = ST_SUGG;
               end
            end
         end
         ST_SUGG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = EV_SUGGEST;
               rsp_var_in   = top_node.node_var;
               rsp_neg_in   = !top_node.tried_neg;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_ff <= rsp_event_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // row of stack cells
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      node_type above_d;
      node_type below_d;

      if (i == 0) begin : g_top
         assign above_d = new_node;
         assign cell_ctl[i] = '{load_above: do_push | do_update, load_below: do_pop};
      end else begin : g_mid
         assign above_d = cell_q[i-1];
         assign cell_ctl[i] = '{load_above: do_push, load_below: do_pop};
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_d = cell_q[i];
      end else begin : g_inner
         assign below_d = cell_q[i+1];
      end

      ddts_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .above_d (above_d),
         .below_d (below_d),
         .node_q  (cell_q[i])
      );
   end

   // response channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - VAR_W - 1){1'b0}}, rsp_neg_ff, rsp_var_ff};
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/ddts_cell.sv
`default_nettype none

module ddts_cell (
   input  wire logic                  clock,
   input  wire ddts_pkg::cell_ctl_type ctl,
   input  wire ddts_pkg::node_type    above_d,
   input  wire ddts_pkg::node_type    below_d,
   output ddts_pkg::node_type         node_q
);
   import ddts_pkg::*;

   node_type node_ff;
   node_type node_in;

   // push takes the node from above, pop takes the node from below
   always_comb begin
      node_in = node_ff;
      if (ctl.load_above) begin
         node_in = above_d;
      end else if (ctl.load_below) begin
         node_in = below_d;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign node_q = node_ff;

endmodule

`default_nettype wire

// File: src/ddts_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ddts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import ddts_pkg::*;

   logic unused_req_data;
   assign unused_req_data = ^req_tdata;

   // stalled response holds its payload
   `CHK_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled response changed")

   // no response is pending right after reset
   `CHK_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")

   // a decide transfer answers in the next cycle with one closing result
   `CHK_ASSERT(a_decide_reply, req_tvalid && req_tready && req_tuser == KIND_DECIDE |=> rsp_tvalid && rsp_tlast && (rsp_tuser == EV_ACCEPT || rsp_tuser == EV_OVERFLOW), "decide without reply")

   // an unassign is never the closing result, a suggestion always is
   `CHK_ASSERT(a_last_marks, rsp_tvalid |-> (rsp_tuser == EV_UNASSIGN) != rsp_tlast || (rsp_tuser != EV_UNASSIGN && rsp_tuser != EV_SUGGEST), "wrong last marker")

endmodule

bind dpll_decision_trail_stack ddts_checker u_checker (.*);

`default_nettype wire
